// ----- src/uts2c_pkg.sv -----
// Package for the unix seconds to calendar converter.
// Holds the sequencer state type, the result record and calendar constants.
// No dependencies.
package uts2c_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DAY,
		ST_TOD,
		ST_MINS,
		ST_SEC,
		ST_HOUR,
		ST_MIN,
		ST_WDIV,
		ST_WDAY,
		ST_YEAR,
		ST_LEAP,
		ST_MONTH,
		ST_DONE
	} state_t;

	// packed from the lowest bit up: second, minute, hour, weekday, year, yday, month, mday
	typedef struct packed {
		logic [4:0] day_of_month;
		logic [3:0] month_index;
		logic [8:0] day_of_year;
		logic [7:0] years_since_1900;
		logic [2:0] weekday;
		logic [4:0] hour_of_day;
		logic [5:0] minute_of_hour;
		logic [5:0] second_of_minute;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

	// reciprocals, exact over the operand ranges that reach them
	localparam logic [25:0] RECIP_DAY  = 26'd50903317; // ceil(2^35 / 675), on seconds / 128
	localparam logic [25:0] RECIP_MIN  = 26'd34953;    // ceil(2^19 / 15), on seconds / 4
	localparam logic [25:0] RECIP_HOUR = 26'd547;      // ceil(2^13 / 15), on minutes / 4
	localparam logic [25:0] RECIP_WEEK = 26'd74899;    // ceil(2^19 / 7)
	localparam logic [25:0] DAY_DIV    = 26'd675;      // 86400 / 128
	localparam logic [25:0] MIN_DIV    = 26'd60;
	localparam logic [25:0] WEEK_DIV   = 26'd7;

	localparam logic [17:0] DAYS_LEAP     = 18'd366;
	localparam logic [17:0] DAYS_NORMAL   = 18'd365;
	localparam logic [15:0] EPOCH_WDAY    = 16'd4;
	localparam logic [7:0]  EPOCH_YEAR    = 8'd70;
	localparam logic [7:0]  YEAR_2100     = 8'd200;
	localparam logic [15:0] FEB_29        = 16'd59;
	localparam logic [3:0]  LAST_MONTH    = 4'd11;

	// Years reachable are 1970..2106: 2000 is leap, 2100 is not.
	function automatic logic is_leap(input logic [7:0] yoff);
		return (yoff[1:0] == 2'b00) && (yoff != YEAR_2100);
	endfunction

	function automatic logic [8:0] month_start(input logic [3:0] mon);
		logic [8:0] r;
		unique case (mon)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd59;
			4'd3:    r = 9'd90;
			4'd4:    r = 9'd120;
			4'd5:    r = 9'd151;
			4'd6:    r = 9'd181;
			4'd7:    r = 9'd212;
			4'd8:    r = 9'd243;
			4'd9:    r = 9'd273;
			4'd10:   r = 9'd304;
			4'd11:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- src/uts2c_core.sv -----
// Conversion sequencer with one shared 26x26 multiplier and one 18-bit subtract/compare unit.
// Constant divisions by reciprocal multiply, then the year walk and month search.
// Depends on uts2c_pkg.
module uts2c_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        epoch_seconds,
	output logic               idle,
	output logic               done,
	input  logic               take,
	output uts2c_pkg::result_t result
);
	import uts2c_pkg::*;

	state_t      state_q, state_d;
	logic [31:0] acc_q;
	logic [15:0] days_q;
	logic [10:0] mins_q;
	result_t     res_q;

	logic [25:0] mul_a, mul_b;
	logic [51:0] prod;
	logic [17:0] sub_a, sub_b;
	logic [18:0] diff;
	logic        ge;
	logic [15:0] wday_n;

	assign wday_n = days_q + EPOCH_WDAY;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_DAY: begin
				mul_a = {1'b0, acc_q[31:7]};
				mul_b = RECIP_DAY;
			end
			ST_TOD: begin
				mul_a = {10'd0, days_q};
				mul_b = DAY_DIV;
			end
			ST_MINS: begin
				mul_a = {11'd0, acc_q[16:2]};
				mul_b = RECIP_MIN;
			end
			ST_SEC: begin
				mul_a = {15'd0, mins_q};
				mul_b = MIN_DIV;
			end
			ST_HOUR: begin
				mul_a = {17'd0, mins_q[10:2]};
				mul_b = RECIP_HOUR;
			end
			ST_MIN: begin
				mul_a = {21'd0, res_q.hour_of_day};
				mul_b = MIN_DIV;
			end
			ST_WDIV: begin
				mul_a = {10'd0, wday_n};
				mul_b = RECIP_WEEK;
			end
			ST_WDAY: begin
				mul_a = {13'd0, acc_q[12:0]};
				mul_b = WEEK_DIV;
			end
			default: begin
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// remainders only need the low bits of the difference
	always_comb begin
		sub_a = '0;
		sub_b = prod[17:0];
		unique case (state_q)
			ST_TOD:  sub_a = {8'd0, acc_q[16:7]};
			ST_SEC:  sub_a = {12'd0, acc_q[5:0]};
			ST_MIN:  sub_a = {12'd0, mins_q[5:0]};
			ST_WDAY: sub_a = {2'b00, wday_n};
			ST_YEAR: begin
				sub_a = {2'b00, days_q};
				sub_b = is_leap(res_q.years_since_1900) ? DAYS_LEAP : DAYS_NORMAL;
			end
			ST_MONTH: begin
				sub_a = {2'b00, days_q};
				sub_b = {9'd0, month_start(res_q.month_index)};
			end
			default: begin
			end
		endcase
	end

	assign diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign ge   = ~diff[18];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_DAY;
			ST_DAY:   state_d = ST_TOD;
			ST_TOD:   state_d = ST_MINS;
			ST_MINS:  state_d = ST_SEC;
			ST_SEC:   state_d = ST_HOUR;
			ST_HOUR:  state_d = ST_MIN;
			ST_MIN:   state_d = ST_WDIV;
			ST_WDIV:  state_d = ST_WDAY;
			ST_WDAY:  state_d = ST_YEAR;
			ST_YEAR:  if (!ge) state_d = ST_LEAP;
			ST_LEAP:  state_d = ST_MONTH;
			ST_MONTH: if (ge) state_d = ST_DONE;
			ST_DONE:  if (take) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				acc_q <= epoch_seconds;
			end
			ST_DAY: begin
				days_q <= prod[50:35];
			end
			ST_TOD: begin
				acc_q <= {15'd0, diff[9:0], acc_q[6:0]};
			end
			ST_MINS: begin
				mins_q <= prod[29:19];
			end
			ST_SEC: begin
				res_q.second_of_minute <= diff[5:0];
			end
			ST_HOUR: begin
				res_q.hour_of_day <= prod[17:13];
			end
			ST_MIN: begin
				res_q.minute_of_hour <= diff[5:0];
			end
			ST_WDIV: begin
				acc_q <= {19'd0, prod[31:19]};
			end
			ST_WDAY: begin
				res_q.weekday          <= diff[2:0];
				res_q.years_since_1900 <= EPOCH_YEAR;
			end
			ST_YEAR: begin
				if (ge) begin
					days_q <= diff[15:0];
					res_q.years_since_1900 <= res_q.years_since_1900 + 8'd1;
				end else begin
					res_q.day_of_year  <= days_q[8:0];
					res_q.day_of_month <= 5'd1;
				end
			end
			ST_LEAP: begin
				res_q.month_index <= LAST_MONTH;
				if (is_leap(res_q.years_since_1900) && days_q >= FEB_29) begin
					if (days_q == FEB_29) res_q.day_of_month <= 5'd2;
					days_q <= days_q - 16'd1;
				end
			end
			ST_MONTH: begin
				if (ge) begin
					res_q.day_of_month <= res_q.day_of_month + diff[4:0];
				end else begin
					res_q.month_index <= res_q.month_index - 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign idle   = (state_q == ST_IDLE);
	assign done   = (state_q == ST_DONE);
	assign result = res_q;

endmodule

// ----- src/unix_seconds_to_calendar_top.sv -----
// Top level of the unix seconds to calendar converter.
// Stream handshake and output register around the conversion sequencer.
// Depends on uts2c_pkg and uts2c_core.
//
// Usage:
//   Slave channel s_*: one transfer carries a 32-bit unsigned count of seconds
//   since 1970-01-01 00:00:00 UTC. s_tready is high only while the sequencer
//   is idle; one item is converted at a time.
//   Master channel m_*: one transfer per input with the broken-down UTC time.
//   From input transfer to m_tvalid the sequencer runs 8 reciprocal
//   multiply/subtract steps for time of day and weekday, one year walk step
//   per year plus a final compare (1 to 137), one leap step, 1 to 12 month
//   search steps and one hand-off step. The year walk on the shared
//   subtract/compare unit takes the longest. The next input can be accepted
//   in the cycle after the hand-off, and not before it.
//   The result sits in an output register; a new input is taken while it
//   waits, and the sequencer holds its finished result until that register
//   frees up when the receiver stalls.
//   Reset clears the sequencer and the output valid; nothing else is kept.
module unix_seconds_to_calendar_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] epoch_seconds
	output logic        m_tvalid,
	input  logic        m_tready,
	// [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
	// [19:17] weekday, [27:20] years_since_1900, [36:28] day_of_year,
	// [40:37] month_index, [45:41] day_of_month, [47:46] zero
	output logic [47:0] m_tdata
);
	import uts2c_pkg::*;

	logic    core_idle, core_done, take;
	result_t core_res;
	logic    m_tvalid_q;
	result_t m_res_q;

	assign take = core_done && (!m_tvalid_q || m_tready);

	uts2c_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (s_tvalid && core_idle),
		.epoch_seconds (s_tdata),
		.idle          (core_idle),
		.done          (core_done),
		.take          (take),
		.result        (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) m_res_q <= core_res;
	end

	assign s_tready = core_idle;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(48 - RESULT_W){1'b0}}, m_res_q};

endmodule

// ----- src/uts2c_chk.sv -----
// Port-level checker for unix_seconds_to_calendar_top, bound to the top level.
// Checks output hold under stall, busy after a transfer and field ranges.
// No dependencies beyond the bound ports.
module uts2c_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transfer");

	a_clock: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[5:0] < 6'd60 && m_tdata[11:6] < 6'd60
			&& m_tdata[16:12] < 5'd24 && m_tdata[19:17] < 3'd7)
		else $error("time of day field out of range");

	a_date: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[40:37] <= 4'd11 && m_tdata[45:41] != 5'd0
			&& m_tdata[36:28] <= 9'd365 && m_tdata[27:20] >= 8'd70
			&& m_tdata[47:46] == 2'b00)
		else $error("date field out of range");

endmodule

bind unix_seconds_to_calendar_top uts2c_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- test/testbench.sv -----
// Testbench for unix_seconds_to_calendar_top: directed and random epoch counts
// go in, each result is checked against an in-house calendar predictor.
// Depends on uts2c_pkg and the converter RTL.
`timescale 1ns / 100ps

module testbench;
	import uts2c_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS   = 1630;
	localparam int TAIL_CYCLES    = 300;

	class calendar_scoreboard;
		result_t     expected_dates[$];
		int unsigned failures;

		static function bit gregorian_leap(int unsigned yr);
			return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
		endfunction

		static function int unsigned first_day_of_month(int unsigned mon);
			int unsigned firsts[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
			return firsts[mon];
		endfunction

		static function result_t calendar_of(logic [31:0] secs);
			result_t     r;
			int unsigned t, tod, days, yr, mon, mday;
			t    = secs;
			tod  = t % 86400;
			days = t / 86400;
			r.second_of_minute = 6'(tod % 60);
			r.minute_of_hour   = 6'((tod / 60) % 60);
			r.hour_of_day      = 5'(tod / 3600);
			r.weekday          = 3'((days + 4) % 7);
			yr = 1970;
			while (days >= (gregorian_leap(yr) ? 366 : 365)) begin
				days -= gregorian_leap(yr) ? 366 : 365;
				yr++;
			end
			r.years_since_1900 = 8'(yr - 1900);
			r.day_of_year      = 9'(days);
			mday = 1;
			if (gregorian_leap(yr) && days > 58) begin
				if (days == 59)
					mday = 2;
				days--;
			end
			mon = 11;
			while (mon > 0 && first_day_of_month(mon) > days)
				mon--;
			mday += days - first_day_of_month(mon);
			r.month_index  = 4'(mon);
			r.day_of_month = 5'(mday);
			return r;
		endfunction

		function void note_epoch(logic [31:0] secs);
			expected_dates.push_back(calendar_of(secs));
		endfunction

		function int pending();
			return expected_dates.size();
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				failures++;
			end
		endfunction

		function void check_date(logic [47:0] data);
			result_t want, got;
			if (expected_dates.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, data);
				failures++;
				return;
			end
			want = expected_dates.pop_front();
			got  = data[45:0];
			compare_field("second_of_minute", want.second_of_minute, got.second_of_minute);
			compare_field("minute_of_hour", want.minute_of_hour, got.minute_of_hour);
			compare_field("hour_of_day", want.hour_of_day, got.hour_of_day);
			compare_field("weekday", want.weekday, got.weekday);
			compare_field("years_since_1900", want.years_since_1900, got.years_since_1900);
			compare_field("day_of_year", want.day_of_year, got.day_of_year);
			compare_field("month_index", want.month_index, got.month_index);
			compare_field("day_of_month", want.day_of_month, got.day_of_month);
			compare_field("padding", 0, data[47:46]);
		endfunction

		function void report_leftovers();
			if (expected_dates.size() != 0) begin
				$display("%0t: %0d results missing, expected %h first, actual none",
					$time, expected_dates.size(), expected_dates[0]);
				failures++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;

	calendar_scoreboard sb = new();
	bit                 steady;
	int                 rx_hold = 0;
	int                 quiet_cycles = 0;

	unix_seconds_to_calendar_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic int idle_length();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(50, 300);
	endfunction

	function automatic longint unsigned days_before_year(int unsigned yr);
		longint unsigned d;
		d = 0;
		for (int unsigned y = 1970; y < yr; y++)
			d += calendar_scoreboard::gregorian_leap(y) ? 366 : 365;
		return d;
	endfunction

	// Four in ten draws pick dates around February's end and New Year, the rest anywhere.
	function automatic logic [31:0] random_epoch();
		int unsigned     day_picks[7] = '{0, 57, 58, 59, 60, 364, 365};
		longint unsigned secs;
		int unsigned     tod;
		int              r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return $urandom();
		case ($urandom_range(0, 3))
			0:       tod = 0;
			1:       tod = 86399;
			default: tod = $urandom_range(0, 86399);
		endcase
		if (r < 8)
			secs = (days_before_year(1970 + $urandom_range(0, 136)) +
				day_picks[$urandom_range(0, 6)]) * 86400 + tod;
		else
			secs = longint'($urandom_range(0, 49710)) * 86400 + tod;
		if (secs > 64'hFFFF_FFFF)
			return $urandom();
		return secs[31:0];
	endfunction

	task automatic send_epoch(logic [31:0] secs);
		int gap;
		gap = idle_length();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= secs;
		do @(posedge clk); while (!s_tready);
		sb.note_epoch(secs);
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_date(m_tdata);
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!steady && $urandom_range(0, 3) == 0)
					rx_hold = idle_length();
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [31:0] directed[$] = '{
			32'd0, 32'hFFFF_FFFF, 32'd86399, 32'd86400,
			32'd68169599, 32'd68169600, 32'd68256000, 32'd94694399,
			32'd946684799, 32'd946684800, 32'd951782400, 32'd978307199,
			32'd2147483647, 32'd2147483648, 32'd4102444800, 32'd4107456000,
			32'd4107542399, 32'd4107542400, 32'd4291747199, 32'h5555_5555,
			32'hAAAA_AAAA, 32'd1234567890
		};
		arst_n       <= 1'b0;
		s_tvalid     <= 1'b0;
		s_tdata      <= '0;
		steady       = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_epoch(directed[i]);
		wait_for_results();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i % 400) >= 340;
			if (i == RANDOM_ITEMS / 2)
				wait_for_results();
			send_epoch(random_epoch());
		end
		s_tvalid <= 1'b0;
		steady   = 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.report_leftovers();
		if (sb.failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
